// ===== rtl/core/hkr_pkg.sv =====
package hkr_pkg;

  localparam int unsigned KeyW      = 7;
  localparam int unsigned VkW       = 8;
  localparam int unsigned FramesW   = 16;
  localparam int unsigned CountOutW = 5;

  localparam logic [FramesW-1:0] FramesMax = '1;

  typedef enum logic [1:0] {
    OP_KEY_DOWN = 2'd0,
    OP_KEY_UP   = 2'd1,
    OP_TICK     = 2'd2,
    OP_QUERY    = 2'd3
  } hkr_op_e;

  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_QUERY  = 3'd4
  } hkr_cmd_e;

  typedef struct packed {
    logic [1:0]     operation;
    logic [VkW-1:0] vk_code;
    logic [KeyW-1:0] query_key;
    logic           held_mode;
  } hkr_req_t;

  typedef struct packed {
    logic                 key_active;
    logic [CountOutW-1:0] active_count;
  } hkr_rsp_t;

  typedef struct packed {
    hkr_cmd_e        kind;
    logic [KeyW-1:0] key;
    logic            held_mode;
  } hkr_cmd_t;

  // Raw virtual key code to compact key code, 0 when unmapped.
  function automatic logic [KeyW-1:0] hkr_translate(input logic [VkW-1:0] vk);
    logic [KeyW-1:0] key;
    key = '0;
    case (vk) inside
      [8'h41:8'h5A]:          key = KeyW'(vk - 8'h40);
      [8'h30:8'h39]:          key = KeyW'(vk - 8'h15);
      [8'h70:8'h7B]:          key = KeyW'(vk - 8'h4B);
      8'h1B:                  key = 7'd49;
      8'h09:                  key = 7'd50;
      8'h14:                  key = 7'd51;
      8'h10, 8'hA0, 8'hA1:    key = 7'd52;
      8'h11, 8'hA2, 8'hA3:    key = 7'd53;
      8'h12, 8'hA4, 8'hA5:    key = 7'd54;
      8'h5B, 8'h5C:           key = 7'd55;
      8'h20:                  key = 7'd56;
      8'h0D:                  key = 7'd57;
      8'h08:                  key = 7'd58;
      8'h26:                  key = 7'd59;
      8'h28:                  key = 7'd60;
      8'h25:                  key = 7'd61;
      8'h27:                  key = 7'd62;
      8'hC0:                  key = 7'd63;
      8'hBD:                  key = 7'd64;
      8'hBB:                  key = 7'd65;
      8'hDB:                  key = 7'd66;
      8'hDD:                  key = 7'd67;
      8'hDC:                  key = 7'd68;
      8'hBA:                  key = 7'd69;
      8'hDE:                  key = 7'd70;
      8'hBC:                  key = 7'd71;
      8'hBE:                  key = 7'd72;
      8'hBF:                  key = 7'd73;
      default:                key = '0;
    endcase
    return key;
  endfunction

endpackage

// ===== rtl/core/hkr_front.sv =====
module hkr_front import hkr_pkg::*; (
  input  logic     start_i,
  input  logic     full_i,
  input  hkr_req_t req_i,
  output logic     busy_o,
  output logic     push_o,
  output hkr_cmd_t cmd_o
);

  logic [KeyW-1:0] vk_key;

  assign vk_key = hkr_translate(req_i.vk_code);
  assign busy_o = full_i;
  assign push_o = start_i & ~full_i;

  always_comb begin
    cmd_o.held_mode = req_i.held_mode;
    cmd_o.key       = vk_key;
    cmd_o.kind      = CMD_NOP;
    unique case (req_i.operation)
      OP_KEY_DOWN: cmd_o.kind = (vk_key != '0) ? CMD_ADD : CMD_NOP;
      OP_KEY_UP:   cmd_o.kind = (vk_key != '0) ? CMD_REMOVE : CMD_NOP;
      OP_TICK:     cmd_o.kind = CMD_TICK;
      OP_QUERY: begin
        // key 0 never sits in a used slot, so the lookup answers 0 by itself
        cmd_o.kind = CMD_QUERY;
        cmd_o.key  = req_i.query_key;
      end
      default:     cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/core/hkr_queue.sv =====
module hkr_queue import hkr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hkr_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output hkr_cmd_t cmd_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hkr_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign do_pop  = pop_i & valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/hkr_back.sv =====
module hkr_back import hkr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  hkr_cmd_t cmd_i,
  output logic     pop_o,
  output logic     result_valid_o,
  output hkr_rsp_t rsp_o
);

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);

  logic [KeyW-1:0]    slot_key_q    [TABLE_SLOTS];
  logic [KeyW-1:0]    slot_key_d    [TABLE_SLOTS];
  logic [FramesW-1:0] slot_frames_q [TABLE_SLOTS];
  logic [FramesW-1:0] slot_frames_d [TABLE_SLOTS];
  logic [CntW-1:0]    occ_q, occ_d;

  logic [TABLE_SLOTS-1:0] used;
  logic [TABLE_SLOTS-1:0] match;
  logic [TABLE_SLOTS-1:0] fresh;
  logic [TABLE_SLOTS-1:0] shift;
  logic [IdxW-1:0]        hit_idx;
  logic                   hit;
  logic                   full;
  logic                   active;

  logic [CntW+CountOutW-1:0] occ_wide;
  hkr_rsp_t                  rsp_q, rsp_d;
  logic                      result_valid_q;

  assign pop_o = valid_i;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      used[i]  = (CntW'(i) < occ_q);
      match[i] = used[i] && (slot_key_q[i] == cmd_i.key);
      fresh[i] = (slot_frames_q[i] == '0);
      if (match[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      shift[i] = (IdxW'(i) >= hit_idx);
    end
  end

  assign hit  = |match;
  assign full = (occ_q == CntW'(TABLE_SLOTS));

  always_comb begin
    slot_key_d    = slot_key_q;
    slot_frames_d = slot_frames_q;
    occ_d         = occ_q;
    active        = 1'b0;
    if (valid_i) begin
      unique case (cmd_i.kind)
        CMD_ADD: begin
          if (!hit && !full) begin
            slot_key_d[occ_q[IdxW-1:0]]    = cmd_i.key;
            slot_frames_d[occ_q[IdxW-1:0]] = '0;
            occ_d                          = occ_q + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (hit) begin
            // slots at and above the hit move down one place; the top one empties
            for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
              if (shift[i]) begin
                slot_key_d[i]    = slot_key_q[i+1];
                slot_frames_d[i] = slot_frames_q[i+1];
              end
            end
            slot_key_d[TABLE_SLOTS-1]    = '0;
            slot_frames_d[TABLE_SLOTS-1] = '0;
            occ_d                        = occ_q - 1'b1;
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (used[i] && (slot_frames_q[i] != FramesMax)) begin
              slot_frames_d[i] = slot_frames_q[i] + 1'b1;
            end
          end
        end
        CMD_QUERY: active = hit && (cmd_i.held_mode || |(match & fresh));
        default: ;
      endcase
    end
  end

  assign occ_wide = {{CountOutW{1'b0}}, occ_d};

  always_comb begin
    rsp_d                = rsp_q;
    if (valid_i) begin
      rsp_d.key_active   = active;
      rsp_d.active_count = occ_wide[CountOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q          <= '0;
      result_valid_q <= 1'b0;
      rsp_q          <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_key_q[i]    <= '0;
        slot_frames_q[i] <= '0;
      end
    end else begin
      occ_q          <= occ_d;
      result_valid_q <= valid_i;
      rsp_q          <= rsp_d;
      slot_key_q     <= slot_key_d;
      slot_frames_q  <= slot_frames_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

endmodule

// ===== rtl/core/held_key_rollover_table_unit.sv =====
// Channel   Direction  Handshake                      Payload
// request   in         start & !busy at rising edge   req_i  (hkr_req_t)
// result    out        result_valid_o, one cycle      rsp_o  (hkr_rsp_t)
//
// One result per request, via the queue and the result register; a request
// may be accepted every cycle. The table compares and shifts all slots in
// parallel registers; the back end updates them and the result together.
// Reset (rst_ni low) empties the table and the request queue at once.
// Results cannot be held off; busy stays low, as the back end drains the
// queue one request per cycle.
module held_key_rollover_table_unit import hkr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  hkr_req_t req_i,
  output logic     result_valid_o,
  output hkr_rsp_t rsp_o
);

  logic     push;
  logic     full;
  logic     q_valid;
  logic     pop;
  hkr_cmd_t front_cmd;
  hkr_cmd_t back_cmd;

  hkr_front u_front (
    .start_i (start),
    .full_i  (full),
    .req_i   (req_i),
    .busy_o  (busy),
    .push_o  (push),
    .cmd_o   (front_cmd)
  );

  hkr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  hkr_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .cmd_i          (back_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

// ===== rtl/core/hkr_checker.sv =====
module hkr_props import hkr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input hkr_rsp_t rsp_o
);

  // every accepted request is answered, via the queue and the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("request not answered after two cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(rsp_o) |-> result_valid_o)
    else $error("result payload changed without a strobe");

  // back end drains one entry per cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("request queue filled up");

endmodule

bind held_key_rollover_table_unit hkr_props u_hkr_props (.*);

// ===== sim/hkr_checker.sv =====
`timescale 1ns / 1ps

module hkr_checker import hkr_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  hkr_req_t    req_i,
  input  logic        result_valid_i,
  input  hkr_rsp_t    rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned full_rejects_o,
  output int unsigned saturated_o
);

  logic [KeyW-1:0]    held_key    [TABLE_SLOTS];
  logic [FramesW-1:0] held_frames [TABLE_SLOTS];
  int unsigned        held_cnt;
  hkr_rsp_t           expected_q [$];

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    checked_o      = 0;
    full_rejects_o = 0;
    saturated_o    = 0;
    held_cnt       = 0;
  end

  function automatic logic [KeyW-1:0] key_of_vk(input logic [VkW-1:0] vk);
    if (vk >= 8'h41 && vk <= 8'h5A) return KeyW'(1 + (vk - 8'h41));
    if (vk >= 8'h30 && vk <= 8'h39) return KeyW'(27 + (vk - 8'h30));
    if (vk >= 8'h70 && vk <= 8'h7B) return KeyW'(37 + (vk - 8'h70));
    case (vk)
      8'h1B:               return 7'd49;
      8'h09:               return 7'd50;
      8'h14:               return 7'd51;
      8'h10, 8'hA0, 8'hA1: return 7'd52;
      8'h11, 8'hA2, 8'hA3: return 7'd53;
      8'h12, 8'hA4, 8'hA5: return 7'd54;
      8'h5B, 8'h5C:        return 7'd55;
      8'h20:               return 7'd56;
      8'h0D:               return 7'd57;
      8'h08:               return 7'd58;
      8'h26:               return 7'd59;
      8'h28:               return 7'd60;
      8'h25:               return 7'd61;
      8'h27:               return 7'd62;
      8'hC0:               return 7'd63;
      8'hBD:               return 7'd64;
      8'hBB:               return 7'd65;
      8'hDB:               return 7'd66;
      8'hDD:               return 7'd67;
      8'hDC:               return 7'd68;
      8'hBA:               return 7'd69;
      8'hDE:               return 7'd70;
      8'hBC:               return 7'd71;
      8'hBE:               return 7'd72;
      8'hBF:               return 7'd73;
      default:             return '0;
    endcase
  endfunction

  // slot index of a held key, -1 when absent
  function automatic int find_held(input logic [KeyW-1:0] key);
    for (int i = 0; i < held_cnt; i++) begin
      if (held_key[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_request(input hkr_req_t r, output hkr_rsp_t rsp);
    logic [KeyW-1:0] key;
    int              idx;
    rsp = '0;
    case (hkr_op_e'(r.operation))
      OP_KEY_DOWN: begin
        key = key_of_vk(r.vk_code);
        if (key != '0 && find_held(key) < 0) begin
          if (held_cnt >= TABLE_SLOTS) begin
            full_rejects_o++;
          end else begin
            held_key[held_cnt]    = key;
            held_frames[held_cnt] = '0;
            held_cnt++;
          end
        end
      end
      OP_KEY_UP: begin
        key = key_of_vk(r.vk_code);
        idx = (key == '0) ? -1 : find_held(key);
        if (idx >= 0) begin
          for (int i = idx; i + 1 < held_cnt; i++) begin
            held_key[i]    = held_key[i+1];
            held_frames[i] = held_frames[i+1];
          end
          held_key[held_cnt-1]    = '0;
          held_frames[held_cnt-1] = '0;
          held_cnt--;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < held_cnt; i++) begin
          if (held_key[i] != '0) begin
            if (held_frames[i] != FramesMax) held_frames[i]++;
            else saturated_o++;
          end
        end
      end
      OP_QUERY: begin
        idx = (r.query_key == '0) ? -1 : find_held(r.query_key);
        if (idx >= 0) rsp.key_active = r.held_mode || (held_frames[idx] == '0);
      end
    endcase
    rsp.active_count = CountOutW'(held_cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    hkr_rsp_t new_rsp;
    hkr_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        held_key[i]    = '0;
        held_frames[i] = '0;
      end
      held_cnt = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (start_i && !busy_i) begin
        apply_request(req_i, new_rsp);
        expected_q.push_back(new_rsp);
      end
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with no request pending: key_active=%0d active_count=%0d",
                     $time, rsp_i.key_active, rsp_i.active_count);
          end
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (rsp_i.key_active !== want.key_active ||
              rsp_i.active_count !== want.active_count) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch key_active exp %0d got %0d, active_count exp %0d got %0d",
                       $time, want.key_active, rsp_i.key_active,
                       want.active_count, rsp_i.active_count);
            end
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_held_key_rollover_table_unit.sv =====
`timescale 1ns / 1ps

module tb_held_key_rollover_table_unit;
  import hkr_pkg::*;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned RandItems   = 1000;
  localparam int unsigned QuietTail   = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  hkr_req_t    req;
  logic        result_valid;
  hkr_rsp_t    rsp;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_rejects;
  int unsigned saturated;

  bit          idling;
  int unsigned sent;
  logic [VkW-1:0] pressed [16];
  int unsigned    press_wr;

  held_key_rollover_table_unit #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .rsp_o          (rsp)
  );

  hkr_checker #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (result_valid),
    .rsp_i          (rsp),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_rejects_o (full_rejects),
    .saturated_o    (saturated)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still pending", pending);
    $display("== FAIL ==");
    $finish;
  end

  // mapped codes used to fill the table in the directed part
  function automatic logic [VkW-1:0] fill_code(input int k);
    case (k)
      0:  return 8'h5A;
      1:  return 8'h30;
      2:  return 8'h39;
      3:  return 8'h70;
      4:  return 8'h7B;
      5:  return 8'h1B;
      6:  return 8'h09;
      7:  return 8'h14;
      8:  return 8'hBF;
      9:  return 8'hC0;
      10: return 8'h5C;
      11: return 8'h20;
      12: return 8'h0D;
      13: return 8'hA5;
      default: return 8'h08;
    endcase
  endfunction

  function automatic logic [VkW-1:0] rand_mapped_vk();
    case ($urandom_range(0, 4))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h30 + 8'($urandom_range(0, 9));
      2: return 8'h70 + 8'($urandom_range(0, 11));
      3: begin
        // each group of modifier aliases shares one key
        case ($urandom_range(0, 10))
          0: return 8'h10;  1: return 8'hA0;  2: return 8'hA1;
          3: return 8'h11;  4: return 8'hA2;  5: return 8'hA3;
          6: return 8'h12;  7: return 8'hA4;  8: return 8'hA5;
          9: return 8'h5B;  default: return 8'h5C;
        endcase
      end
      default: begin
        case ($urandom_range(0, 20))
          0:  return 8'hBA;  1:  return 8'hBB;  2:  return 8'hBC;
          3:  return 8'hBD;  4:  return 8'hBE;  5:  return 8'hBF;
          6:  return 8'hC0;  7:  return 8'hDB;  8:  return 8'hDC;
          9:  return 8'hDD;  10: return 8'hDE;  11: return 8'h1B;
          12: return 8'h09;  13: return 8'h14;  14: return 8'h20;
          15: return 8'h0D;  16: return 8'h08;  17: return 8'h25;
          18: return 8'h26;  19: return 8'h27;  default: return 8'h28;
        endcase
      end
    endcase
  endfunction

  task automatic send_req(input hkr_op_e op, input logic [VkW-1:0] vk,
                          input logic [KeyW-1:0] qk, input logic hm);
    hkr_req_t    r;
    logic [31:0] noise;
    int          gap_len;
    r.operation = op;
    r.vk_code   = vk;
    r.query_key = qk;
    r.held_mode = hm;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 3);
      repeat (gap_len) begin
        @(negedge clk_i);
        noise = $urandom;
        start <= 1'b0;
        req   <= noise[$bits(hkr_req_t)-1:0];
      end
    end
    @(negedge clk_i);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  initial begin : stimulus
    int unsigned    sel;
    int unsigned    down_lim;
    int unsigned    waited;
    logic [VkW-1:0] vk;
    logic [KeyW-1:0] qk;
    hkr_op_e        op;

    rst_ni   = 1'b0;
    start    = 1'b0;
    req      = '0;
    idling   = 1'b1;
    sent     = 0;
    press_wr = 0;
    for (int i = 0; i < 16; i++) pressed[i] = 8'h41;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, unmapped codes, repeats, aliases, first frame
    send_req(OP_QUERY,    8'h00, 7'd1,   1'b1);
    send_req(OP_KEY_DOWN, 8'h00, 7'd0,   1'b0);
    send_req(OP_KEY_DOWN, 8'hFF, 7'h7F,  1'b1);
    send_req(OP_KEY_DOWN, 8'h41, 7'd0,   1'b0);
    send_req(OP_KEY_DOWN, 8'h41, 7'd0,   1'b0);
    send_req(OP_QUERY,    8'h00, 7'd1,   1'b0);
    send_req(OP_TICK,     8'h00, 7'd0,   1'b0);
    send_req(OP_QUERY,    8'h00, 7'd1,   1'b0);
    send_req(OP_QUERY,    8'h00, 7'd1,   1'b1);
    send_req(OP_KEY_DOWN, 8'hA0, 7'd0,   1'b0);
    send_req(OP_KEY_DOWN, 8'h10, 7'd0,   1'b0);
    send_req(OP_KEY_UP,   8'hA1, 7'd0,   1'b0);
    send_req(OP_KEY_UP,   8'h5A, 7'd0,   1'b0);
    send_req(OP_KEY_UP,   8'hFF, 7'd0,   1'b0);
    send_req(OP_QUERY,    8'hFF, 7'd0,   1'b1);
    send_req(OP_QUERY,    8'hFF, 7'h7F,  1'b1);
    send_req(OP_QUERY,    8'hFF, 7'd74,  1'b1);

    // fill to capacity, then a press that must be dropped
    for (int k = 0; k < 15; k++) send_req(OP_KEY_DOWN, fill_code(k), 7'd0, 1'b0);
    send_req(OP_KEY_DOWN, 8'h42, 7'd0,  1'b0);
    send_req(OP_QUERY,    8'h00, 7'd73, 1'b0);
    send_req(OP_QUERY,    8'h00, 7'd2,  1'b1);
    send_req(OP_KEY_UP,   8'h41, 7'd0,  1'b0);
    send_req(OP_TICK,     8'h00, 7'd0,  1'b0);
    send_req(OP_QUERY,    8'h00, 7'd26, 1'b0);
    for (int k = 0; k < 15; k++) send_req(OP_KEY_UP, fill_code(k), 7'd0, 1'b0);

    // frame counts across back-to-back ticks
    idling = 1'b0;
    send_req(OP_KEY_DOWN, 8'h41, 7'd0, 1'b0);
    repeat (20) send_req(OP_TICK, 8'h00, 7'd0, 1'b0);
    send_req(OP_KEY_DOWN, 8'h42, 7'd0, 1'b0);
    send_req(OP_TICK,     8'h00, 7'd0, 1'b0);
    send_req(OP_QUERY,    8'h00, 7'd1, 1'b1);
    send_req(OP_QUERY,    8'h00, 7'd1, 1'b0);
    send_req(OP_QUERY,    8'h00, 7'd2, 1'b0);
    send_req(OP_KEY_UP,   8'h41, 7'd0, 1'b0);
    send_req(OP_KEY_UP,   8'h42, 7'd0, 1'b0);

    // random: press-heavy and release-heavy phases so the table fills and drains
    for (int unsigned i = 0; i < RandItems; i++) begin
      idling   = (i < RandItems - QuietTail);
      down_lim = ((i / 120) % 2 == 0) ? 45 : 20;
      sel      = $urandom_range(0, 99);
      if (sel < down_lim)  op = OP_KEY_DOWN;
      else if (sel < 70)   op = OP_KEY_UP;
      else if (sel < 85)   op = OP_TICK;
      else                 op = OP_QUERY;

      if ($urandom_range(0, 9) == 0) vk = 8'($urandom_range(0, 255));
      else if (op == OP_KEY_UP && $urandom_range(0, 9) < 7) vk = pressed[$urandom_range(0, 15)];
      else vk = rand_mapped_vk();

      if ($urandom_range(0, 9) < 6) qk = hkr_translate(pressed[$urandom_range(0, 15)]);
      else qk = 7'($urandom_range(0, 127));

      send_req(op, vk, qk, 1'($urandom_range(0, 1)));
      if (op == OP_KEY_DOWN) begin
        pressed[press_wr % 16] = vk;
        press_wr++;
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);

    $display("ran %0d requests (%0d random), %0d results checked, %0d left pending",
             sent, RandItems, checked, pending);
    $display("presses dropped on a full table: %0d, ticks on saturated slots: %0d",
             full_rejects, saturated);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
